// ===== rtl/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/utx_pkg.sv =====
package utx_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  typedef enum logic [1:0] {
    EncUtf8   = 2'd0,
    EncUtf16  = 2'd1,
    EncUtf32  = 2'd2,
    EncLatin1 = 2'd3
  } enc_e;

  typedef enum logic [1:0] {
    StData    = 2'd0,
    StDone    = 2'd1,
    StIllegal = 2'd2,
    StNoRoom  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RegSrcEnc = 2'd0,
    RegDstEnc = 2'd1,
    RegBudget = 2'd2
  } reg_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [1:0]  status;
    logic [31:0] bytes_consumed;
    logic [31:0] bytes_written;
    logic        last_result;
  } out_item_t;

  // front to back: one decoded code point or one status
  typedef struct packed {
    logic        is_status;
    logic [1:0]  status;
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic        add_done;
    logic [31:0] consumed;
    logic [31:0] written;
  } job_t;

  function automatic logic [31:0] sat_report(logic [CountWidth-1:0] v);
    logic [31:0] r;
    if (CountWidth > 32 && (v >> 32) != '0) begin
      r = 32'hFFFF_FFFF;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/utx_front.sv =====
module utx_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  utx_pkg::in_item_t      item_i,
  output logic                   full_o,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output utx_pkg::job_t          job_o,
  output logic                   job_valid_o,
  input  logic                   job_room_i
);

  logic [1:0]  src_q, dst_q;
  logic [31:0] budget_q;
  logic [31:0] seq_q, seq_d;
  logic [2:0]  held_q, held_d, exp_q, exp_d;
  logic [utx_pkg::CountWidth-1:0] cons_q, cons_d, wr_q, wr_d;
  logic        stop_q, stop_d;

  logic        acc;
  logic [7:0]  b;
  logic        last;
  logic [2:0]  nh;
  logic [31:0] sq;
  logic [15:0] lo16, hi16;
  logic [20:0] cp;
  logic        bad, norep;
  logic [2:0]  n;
  logic [utx_pkg::CountWidth:0] wsum;
  logic [utx_pkg::CountWidth:0] csum;
  logic [32:0] wneed;
  utx_pkg::job_t job;
  logic        emit;

  assign full_o = !job_room_i;
  assign acc    = push_i && job_room_i;
  assign b      = item_i.in_byte;
  assign last   = item_i.last_byte;

  always_comb begin
    seq_d  = seq_q;
    held_d = held_q;
    exp_d  = exp_q;
    cons_d = cons_q;
    wr_d   = wr_q;
    stop_d = stop_q;
    emit   = 1'b0;
    job    = '0;
    bad    = 1'b0;
    norep  = 1'b0;
    cp     = '0;
    n      = '0;
    nh     = held_q + 3'd1;
    sq     = seq_q | ({24'd0, b} << {held_q[1:0], 3'b000});
    lo16   = sq[15:0];
    hi16   = sq[31:16];
    wsum   = '0;
    csum   = '0;
    wneed  = '0;
    job.consumed = utx_pkg::sat_report(cons_q);
    job.written  = utx_pkg::sat_report(wr_q);
    job.is_status = 1'b1;
    if (acc) begin
      if (stop_q) begin
        if (last) begin
          seq_d = '0; held_d = '0; exp_d = '0; cons_d = '0; wr_d = '0; stop_d = 1'b0;
        end
      end else begin
        exp_d = exp_q;
        if (nh == 3'd1) begin
          unique case (utx_pkg::enc_e'(src_q))
            utx_pkg::EncUtf8: begin
              if (b < 8'h80) exp_d = 3'd1;
              else if (b[7:5] == 3'b110) exp_d = 3'd2;
              else if (b[7:4] == 4'b1110) exp_d = 3'd3;
              else if (b[7:3] == 5'b11110) exp_d = 3'd4;
              else bad = 1'b1;
            end
            utx_pkg::EncUtf16: exp_d = 3'd2;
            utx_pkg::EncUtf32: exp_d = 3'd4;
            default: exp_d = 3'd1;
          endcase
        end else if (utx_pkg::enc_e'(src_q) == utx_pkg::EncUtf8) begin
          if (b[7:6] != 2'b10) bad = 1'b1;
        end else if (utx_pkg::enc_e'(src_q) == utx_pkg::EncUtf16 && nh == 3'd2) begin
          if (lo16 >= 16'hD800 && lo16 <= 16'hDFFF) begin
            if (lo16 > 16'hDBFF) bad = 1'b1;
            else exp_d = 3'd4;
          end
        end
        if (!bad && nh >= exp_d) begin
          unique case (utx_pkg::enc_e'(src_q))
            utx_pkg::EncUtf8: begin
              unique case (exp_d)
                3'd1: cp = {13'd0, sq[7:0]};
                3'd2: begin
                  cp = {10'd0, sq[4:0], sq[13:8]};
                  bad = cp < 21'h80;
                end
                3'd3: begin
                  cp = {5'd0, sq[3:0], sq[13:8], sq[21:16]};
                  bad = cp < 21'h800;
                end
                default: begin
                  cp = {sq[2:0], sq[13:8], sq[21:16], sq[29:24]};
                  bad = cp < 21'h10000 || cp > 21'h10FFFF;
                end
              endcase
            end
            utx_pkg::EncUtf16: begin
              if (exp_d == 3'd2) begin
                cp = {5'd0, lo16};
              end else begin
                bad = hi16 < 16'hDC00 || hi16 > 16'hDFFF;
                cp  = 21'h10000 + {1'b0, lo16[9:0], hi16[9:0]};
              end
            end
            utx_pkg::EncUtf32: begin
              bad = sq > 32'h10FFFF;
              cp  = sq[20:0];
            end
            default: cp = {13'd0, sq[7:0]};
          endcase
          if (!bad) begin
            unique case (utx_pkg::enc_e'(dst_q))
              utx_pkg::EncUtf8:
                n = cp < 21'h80 ? 3'd1 : cp < 21'h800 ? 3'd2 : cp < 21'h10000 ? 3'd3 : 3'd4;
              utx_pkg::EncUtf16: begin
                norep = cp >= 21'hD800 && cp <= 21'hDFFF;
                n = cp < 21'h10000 ? 3'd2 : 3'd4;
              end
              utx_pkg::EncUtf32: n = 3'd4;
              default: begin
                norep = cp > 21'hFF;
                n = 3'd1;
              end
            endcase
            wsum  = {1'b0, wr_q} + (utx_pkg::CountWidth+1)'(n);
            wneed = (utx_pkg::CountWidth >= 32 && (wsum >> 32) != '0) ? 33'h1_0000_0000
                  : 33'(wsum);
          end
        end
        if (bad) begin
          emit = 1'b1;
          job.status = utx_pkg::StIllegal;
        end else if (nh < exp_d) begin
          if (last) begin
            emit = 1'b1;
            job.status = utx_pkg::StIllegal;
            bad = 1'b1;
          end
        end else if (norep || wneed > {1'b0, budget_q}) begin
          emit = 1'b1;
          bad = 1'b1;
          job.status = utx_pkg::StNoRoom;
        end else begin
          emit = 1'b1;
          csum = {1'b0, cons_q} + (utx_pkg::CountWidth+1)'(exp_d);
          cons_d = csum[utx_pkg::CountWidth] ? '1 : csum[utx_pkg::CountWidth-1:0];
          wr_d   = wsum[utx_pkg::CountWidth] ? '1 : wsum[utx_pkg::CountWidth-1:0];
          job.is_status = 1'b0;
          job.status    = utx_pkg::StDone;
          job.cp        = cp;
          job.nbytes    = n;
          job.add_done  = last;
          job.consumed  = utx_pkg::sat_report(cons_d);
          job.written   = utx_pkg::sat_report(wr_d);
        end
        if (bad) begin
          seq_d = '0; held_d = '0; exp_d = '0; stop_d = 1'b1;
        end else if (nh < exp_d) begin
          seq_d = sq; held_d = nh;
        end else begin
          seq_d = '0; held_d = '0; exp_d = '0;
        end
        if (last) begin
          seq_d = '0; held_d = '0; exp_d = '0; cons_d = '0; wr_d = '0; stop_d = 1'b0;
        end
      end
    end
    if (cfg_valid_i && utx_pkg::reg_e'(cfg_index_i) == utx_pkg::RegSrcEnc) begin
      seq_d = '0; held_d = '0; exp_d = '0;
    end
  end

  assign job_o       = job;
  assign job_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0; dst_q <= '0; budget_q <= '1;
      seq_q <= '0; held_q <= '0; exp_q <= '0;
      cons_q <= '0; wr_q <= '0; stop_q <= 1'b0;
    end else begin
      seq_q <= seq_d; held_q <= held_d; exp_q <= exp_d;
      cons_q <= cons_d; wr_q <= wr_d; stop_q <= stop_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          utx_pkg::RegSrcEnc: src_q <= cfg_data_i[1:0];
          utx_pkg::RegDstEnc: dst_q <= cfg_data_i[1:0];
          utx_pkg::RegBudget: budget_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/utx_back.sv =====
module utx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        dst_i,
  input  utx_pkg::job_t     job_i,
  input  logic              job_valid_i,
  output logic              job_room_o,
  output utx_pkg::out_item_t item_o,
  output logic              empty_o,
  input  logic              pop_i
);

  utx_pkg::job_t q_mem [utx_pkg::QueueDepth];
  logic [utx_pkg::QueueAw-1:0] wp_q, rp_q;
  logic [utx_pkg::QueueAw:0]   cnt_q;
  logic [2:0]  idx_q;
  logic        qpop;
  utx_pkg::job_t h;
  logic [7:0]  bb [4];
  logic [19:0] r;
  logic [15:0] hs, ls;
  logic [2:0]  tot;
  logic        last_item;

  assign job_room_o = cnt_q != (utx_pkg::QueueAw + 1)'(utx_pkg::QueueDepth);
  assign h       = q_mem[rp_q];
  assign empty_o = cnt_q == '0;

  always_comb begin
    r  = 20'(h.cp - 21'h10000);
    hs = {6'd0, r[19:10]} + 16'hD800;
    ls = {6'd0, r[9:0]} + 16'hDC00;
    bb[0] = h.cp[7:0]; bb[1] = h.cp[15:8]; bb[2] = {3'd0, h.cp[20:16]}; bb[3] = '0;
    unique case (utx_pkg::enc_e'(dst_i))
      utx_pkg::EncUtf8: begin
        unique case (h.nbytes)
          3'd1: bb[0] = h.cp[7:0];
          3'd2: begin
            bb[0] = {3'b110, h.cp[10:6]}; bb[1] = {2'b10, h.cp[5:0]};
          end
          3'd3: begin
            bb[0] = {4'b1110, h.cp[15:12]}; bb[1] = {2'b10, h.cp[11:6]};
            bb[2] = {2'b10, h.cp[5:0]};
          end
          default: begin
            bb[0] = {5'b11110, h.cp[20:18]}; bb[1] = {2'b10, h.cp[17:12]};
            bb[2] = {2'b10, h.cp[11:6]}; bb[3] = {2'b10, h.cp[5:0]};
          end
        endcase
      end
      utx_pkg::EncUtf16: begin
        if (h.nbytes == 3'd4) begin
          bb[0] = hs[7:0]; bb[1] = hs[15:8]; bb[2] = ls[7:0]; bb[3] = ls[15:8];
        end
      end
      default: ;
    endcase
    tot       = h.nbytes + {2'd0, h.add_done};
    item_o    = '0;
    last_item = 1'b1;
    if (h.is_status) begin
      item_o.status         = h.status;
      item_o.bytes_consumed = h.consumed;
      item_o.bytes_written  = h.written;
      item_o.last_result    = 1'b1;
    end else if (idx_q == h.nbytes) begin
      item_o.status         = utx_pkg::StDone;
      item_o.bytes_consumed = h.consumed;
      item_o.bytes_written  = h.written;
      item_o.last_result    = 1'b1;
    end else begin
      item_o.out_byte    = bb[idx_q[1:0]];
      item_o.byte_valid  = 1'b1;
      last_item          = idx_q + 3'd1 == tot;
      item_o.last_result = last_item;
    end
    qpop = pop_i && !empty_o && last_item;
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_room_o) q_mem[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; idx_q <= '0;
    end else begin
      if (job_valid_i && job_room_o) wp_q <= wp_q + 1'b1;
      if (qpop) begin
        rp_q  <= rp_q + 1'b1;
        idx_q <= '0;
      end else if (pop_i && !empty_o) begin
        idx_q <= idx_q + 3'd1;
      end
      cnt_q <= cnt_q + {2'd0, job_valid_i && job_room_o} - {2'd0, qpop};
    end
  end

endmodule

// ===== rtl/unicode_transcoder_top.sv =====
// A completed code point is registered into the job queue as its last byte is accepted.
// Throughput: one source byte per cycle while not full; one result per cycle drains a 4-entry
// job queue. A code point expands to up to five results, so long bursts fill it, raising full.
// Reset: asynchronous, active low; encodings UTF-8, budget all ones, run state cleared.
module unicode_transcoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  utx_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output utx_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  utx_pkg::job_t job;
  logic          job_valid, job_room;
  logic [1:0]    dst_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= '0;
    end else if (cfg_valid_i && utx_pkg::reg_e'(cfg_index_i) == utx_pkg::RegDstEnc) begin
      dst_q <= cfg_data_i[1:0];
    end
  end

  utx_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(in_item_i), .full_o(full),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .job_o(job), .job_valid_o(job_valid), .job_room_i(job_room)
  );

  utx_back u_back (
    .clk_i, .rst_ni, .dst_i(dst_q),
    .job_i(job), .job_valid_i(job_valid), .job_room_o(job_room),
    .item_o(out_item_o), .empty_o(empty), .pop_i(pop)
  );

endmodule

// ===== rtl/utx_checker.sv =====
`include "assert_macros.svh"
module utx_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input utx_pkg::out_item_t out_item_o
);
  logic byte_ok;

  assign byte_ok = !out_item_o.byte_valid || out_item_o.status == utx_pkg::StData;

  `ASSERT_ALWAYS(a_status_no_byte, clk_i, rst_ni, empty || byte_ok)
  `ASSERT_ALWAYS(a_status_last, clk_i, rst_ni, empty || out_item_o.byte_valid || out_item_o.last_result)
  `ASSERT_ALWAYS(a_full_not_empty, clk_i, rst_ni, !full || !empty)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
endmodule

bind unicode_transcoder_top utx_checker u_chk (
  .clk_i, .rst_ni, .full, .empty, .pop, .out_item_o
);
